// ===== hdl/dual_stepper_move_arc_sequencer_unit_assert.svh =====
// Assertion macros shared by the sequencer modules.
// Needs only a clock and an active-low reset at the point of use.
`ifndef DUAL_STEPPER_MOVE_ARC_SEQUENCER_UNIT_ASSERT_SVH
`define DUAL_STEPPER_MOVE_ARC_SEQUENCER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define DSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dsm assertion failed");
// next-cycle implication
`define DSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dsm assertion failed");
`else
`define DSM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/dsm_pkg.sv =====
// Shared types, codes and constants for the dual stepper sequencer.
// No dependencies; every other file but the assertion header imports it.
package dsm_pkg;

    localparam int MODE_W     = 3;
    localparam int AMT_W      = 16;
    localparam int COIL_W     = 4;
    localparam int COUNT_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values
    localparam logic [7:0]  OFFSET_RST      = 8'd30;
    localparam logic [7:0]  SPR_RST         = 8'd40;
    localparam logic [15:0] MOVE_SCALE_RST  = 16'd4244;
    localparam logic [15:0] TURN_SCALE_RST  = 16'd4444;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

    // Reciprocals: floor(x/d) = (x * M) >> S over the operand ranges used
    localparam logic [31:0] RECIP_1000       = 32'd2199023256;  // x < 2^32, S = 41
    localparam logic [14:0] RECIP_360        = 15'd23302;       // x < 2^15, S = 23
    localparam logic [29:0] RECIP_45         = 30'd763549742;   // x < 2^29, S = 35
    localparam logic [8:0]  DEG_PER_REV      = 9'd360;

    typedef enum logic [MODE_W-1:0] {
        MODE_MOVE    = 3'd0,
        MODE_TURN    = 3'd1,
        MODE_ARC     = 3'd2,
        MODE_STEP    = 3'd3,
        MODE_RELEASE = 3'd4
    } mode_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET     = 2'd0,
        REG_SPR        = 2'd1,
        REG_MOVE_SCALE = 2'd2,
        REG_TURN_SCALE = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ACT_MOVE = 2'd0,
        ACT_TURN = 2'd1,
        ACT_ARC  = 2'd2
    } act_cmd_t;

    // Request class seen by the controller
    typedef enum logic [2:0] {
        KIND_SCALED,
        KIND_ARC,
        KIND_STEP,
        KIND_RELEASE,
        KIND_OTHER
    } req_kind_t;

    // Datapath operations, one per sequencer step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_MV_MUL,
        OP_MV_DIV,
        OP_MV_DONE,
        OP_ARC_QA,
        OP_ARC_AOUT,
        OP_ARC_AIN,
        OP_ARC_OLO,
        OP_ARC_ODIV,
        OP_ARC_OHI,
        OP_ARC_ILO,
        OP_ARC_IDIV,
        OP_ARC_IHI,
        OP_ARC_DONE,
        OP_TICK,
        OP_RELEASE
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MV_MUL,
        ST_MV_DIV,
        ST_MV_DONE,
        ST_ARC_QA,
        ST_ARC_AOUT,
        ST_ARC_AIN,
        ST_ARC_OLO,
        ST_ARC_ODIV,
        ST_ARC_OHI,
        ST_ARC_ILO,
        ST_ARC_IDIV,
        ST_ARC_IHI,
        ST_ARC_DONE,
        ST_TICK,
        ST_RELEASE,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        dp_op_t op;
        logic   load_in;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        req_kind_t kind;
    } status_t;

    // Half-step coil patterns by phase
    function automatic logic [COIL_W-1:0] phase_pattern(input logic [2:0] ph);
        logic [COIL_W-1:0] pat;
        case (ph)
            3'd0:    pat = 4'h8;
            3'd1:    pat = 4'hA;
            3'd2:    pat = 4'h2;
            3'd3:    pat = 4'h6;
            3'd4:    pat = 4'h4;
            3'd5:    pat = 4'h5;
            3'd6:    pat = 4'h1;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

// ===== hdl/dsm_if.sv =====
// Request and result channel interfaces for the stepper sequencer.
// Depends on dsm_pkg for field widths.
interface dsm_cmd_if import dsm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MODE_W-1:0]       mode;
    logic signed [AMT_W-1:0] amount;
    logic signed [AMT_W-1:0] radius;

    modport source (output valid, mode, amount, radius, input ready);
    modport sink   (input valid, mode, amount, radius, output ready);
endinterface

interface dsm_res_if import dsm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COIL_W-1:0]  left_coils;
    logic [COIL_W-1:0]  right_coils;
    logic [COUNT_W-1:0] step_count;

    modport source (output valid, left_coils, right_coils, step_count, input ready);
    modport sink   (input valid, left_coils, right_coils, step_count, output ready);
endinterface

// ===== hdl/dsm_dp.sv =====
// Datapath: config registers, shared multiplier, arc/move arithmetic,
// wheel phase and Bresenham state, result register. Depends on dsm_pkg and the assertion header.
`include "dual_stepper_move_arc_sequencer_unit_assert.svh"

module dsm_dp import dsm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    op_cmd,
    output status_t                 dp_status,
    input  logic [MODE_W-1:0]       mode,
    input  logic signed [AMT_W-1:0] amount,
    input  logic signed [AMT_W-1:0] radius,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    output logic [COIL_W-1:0]       left_coils,
    output logic [COIL_W-1:0]       right_coils,
    output logic [COUNT_W-1:0]      step_count
);

    // Configuration
    logic [7:0]  offset_reg;
    logic [7:0]  spr_reg;
    logic [15:0] move_scale_reg;
    logic [15:0] turn_scale_reg;

    // Latched operands
    logic        neg_reg,      neg_next;
    logic        turn_reg,     turn_next;
    logic [15:0] mag_reg,      mag_next;
    logic [14:0] ang_reg,      ang_next;
    logic [15:0] rout_reg,     rout_next;
    logic [15:0] rin_reg,      rin_next;
    logic        arc_left_reg, arc_left_next;
    logic        near_reg,     near_next;

    // Arithmetic intermediates
    logic [63:0] prod_reg, prod_next;
    logic [6:0]  qa_reg,   qa_next;
    logic [8:0]  ra_reg,   ra_next;
    logic [23:0] aout_reg, aout_next;
    logic [23:0] ain_reg,  ain_next;
    logic [23:0] lo_reg,   lo_next;
    logic [29:0] nout_reg, nout_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // Motor state
    logic [2:0]  lphase_reg,  lphase_next;
    logic [2:0]  rphase_reg,  rphase_next;
    logic        lrev_reg,    lrev_next;
    logic        rrev_reg,    rrev_next;
    logic        in_left_reg, in_left_next;
    act_cmd_t    act_reg,     act_next;
    logic [33:0] err_reg,     err_next;
    logic [32:0] outer2_reg,  outer2_next;
    logic [32:0] inner2_reg,  inner2_next;
    logic        coils_driven_reg, coils_driven_next;

    // Result
    logic [COIL_W-1:0]  lcoil_reg, lcoil_next;
    logic [COIL_W-1:0]  rcoil_reg, rcoil_next;
    logic [COUNT_W-1:0] scount_reg, scount_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;

    function automatic logic [2:0] advance(input logic [2:0] ph, input logic rev);
        return rev ? ph - 3'd1 : ph + 3'd1;
    endfunction

    // Request class for the controller
    always_comb
    begin
        case (mode)
            MODE_MOVE, MODE_TURN: dp_status.kind = KIND_SCALED;
            MODE_ARC:             dp_status.kind = KIND_ARC;
            MODE_STEP:            dp_status.kind = KIND_STEP;
            MODE_RELEASE:         dp_status.kind = KIND_RELEASE;
            default:              dp_status.kind = KIND_OTHER;
        endcase
    end

    // Input decode, latched on accept
    always_comb
    begin
        logic [15:0] amt_bits;
        logic [15:0] rad_bits;
        logic [15:0] r_mag;
        logic [15:0] off16;
        amt_bits = amount;
        rad_bits = radius;
        off16    = {8'd0, offset_reg};
        r_mag    = rad_bits[15] ? (~rad_bits + 16'd1) : rad_bits;

        neg_next      = neg_reg;
        turn_next     = turn_reg;
        mag_next      = mag_reg;
        ang_next      = ang_reg;
        rout_next     = rout_reg;
        rin_next      = rin_reg;
        arc_left_next = arc_left_reg;
        near_next     = near_reg;
        if (op_cmd.load_in)
        begin
            neg_next      = amt_bits[15];
            turn_next     = (mode == MODE_TURN);
            mag_next      = amt_bits[15] ? (~amt_bits + 16'd1) : amt_bits;
            ang_next      = amt_bits[15] ? 15'd0 : amt_bits[14:0];
            rout_next     = r_mag + off16;
            near_next     = (r_mag < off16);
            rin_next      = (r_mag < off16) ? (off16 - r_mag) : (r_mag - off16);
            arc_left_next = !rad_bits[15];
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op_cmd.op)
            OP_MV_MUL:
            begin
                mul_a = {16'd0, mag_reg};
                mul_b = {16'd0, turn_reg ? turn_scale_reg : move_scale_reg};
            end
            OP_MV_DIV:
            begin
                mul_a = prod_reg[31:0];
                mul_b = RECIP_1000;
            end
            OP_ARC_QA:
            begin
                mul_a = {17'd0, ang_reg};
                mul_b = {17'd0, RECIP_360};
            end
            OP_ARC_AOUT:
            begin
                mul_a = {24'd0, spr_reg};
                mul_b = {16'd0, rout_reg};
            end
            OP_ARC_AIN:
            begin
                mul_a = {24'd0, spr_reg};
                mul_b = {16'd0, rin_reg};
            end
            OP_ARC_OLO:
            begin
                mul_a = {8'd0, aout_reg};
                mul_b = {23'd0, ra_reg};
            end
            OP_ARC_ODIV, OP_ARC_IDIV:
            begin
                mul_a = {3'd0, prod_reg[31:3]};
                mul_b = {2'd0, RECIP_45};
            end
            OP_ARC_OHI:
            begin
                mul_a = {8'd0, aout_reg};
                mul_b = {25'd0, qa_reg};
            end
            OP_ARC_ILO:
            begin
                mul_a = {8'd0, ain_reg};
                mul_b = {23'd0, ra_reg};
            end
            OP_ARC_IHI:
            begin
                mul_a = {8'd0, ain_reg};
                mul_b = {25'd0, qa_reg};
            end
            default: ;
        endcase
    end

    // Arc intermediates: angle split into whole turns and remainder,
    // N = a*qa + floor(a*ra/360) with a = steps_per_rev * radius
    always_comb
    begin
        logic [15:0] qa_deg;
        qa_deg    = 16'(qa_reg) * 16'(DEG_PER_REV);
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
        qa_next   = qa_reg;
        ra_next   = ra_reg;
        aout_next = aout_reg;
        ain_next  = ain_reg;
        lo_next   = lo_reg;
        nout_next = nout_reg;
        case (op_cmd.op)
            OP_ARC_AOUT: qa_next = prod_reg[29:23];
            OP_ARC_AIN:
            begin
                ra_next   = 9'({1'b0, ang_reg} - qa_deg);
                aout_next = prod_reg[23:0];
            end
            OP_ARC_OLO:  ain_next = prod_reg[23:0];
            OP_ARC_OHI,
            OP_ARC_IHI:  lo_next = prod_reg[58:35];
            OP_ARC_ILO:  nout_next = prod_reg[29:0] + {6'd0, lo_reg};
            default: ;
        endcase
    end

    // Motor state, Bresenham terms and step count
    always_comb
    begin
        logic [33:0] err_sub;
        logic        inner_steps;
        logic        lstep;
        logic        rstep;
        logic [29:0] nin;
        err_sub     = err_reg - {1'b0, inner2_reg};
        inner_steps = err_sub[33] || (err_sub == '0);
        nin         = prod_reg[29:0] + {6'd0, lo_reg};
        lstep       = 1'b1;
        rstep       = 1'b1;

        lphase_next       = lphase_reg;
        rphase_next       = rphase_reg;
        lrev_next         = lrev_reg;
        rrev_next         = rrev_reg;
        in_left_next      = in_left_reg;
        act_next          = act_reg;
        err_next          = err_reg;
        outer2_next       = outer2_reg;
        inner2_next       = inner2_reg;
        coils_driven_next = coils_driven_reg;
        count_next        = count_reg;

        case (op_cmd.op)
            OP_MV_DONE:
            begin
                count_next = COUNT_W'(prod_reg[63:41]) + 24'd1;
                lrev_next  = neg_reg;
                rrev_next  = turn_reg ? !neg_reg : neg_reg;
                act_next   = turn_reg ? ACT_TURN : ACT_MOVE;
            end
            OP_ARC_DONE:
            begin
                outer2_next  = {2'd0, nout_reg, 1'b0};
                inner2_next  = {2'd0, nin, 1'b0};
                err_next     = {4'd0, nout_reg};
                in_left_next = arc_left_reg;
                lrev_next    = near_reg && arc_left_reg;
                rrev_next    = near_reg && !arc_left_reg;
                act_next     = ACT_ARC;
                count_next   = (nout_reg >= {6'd0, COUNT_MAX}) ? COUNT_MAX
                                                              : COUNT_W'(nout_reg) + 24'd1;
            end
            OP_TICK:
            begin
                if (act_reg == ACT_ARC)
                begin
                    lstep    = in_left_reg ? inner_steps : 1'b1;
                    rstep    = in_left_reg ? 1'b1 : inner_steps;
                    err_next = inner_steps ? err_sub + {1'b0, outer2_reg} : err_sub;
                end
                lphase_next       = lstep ? advance(lphase_reg, lrev_reg) : lphase_reg;
                rphase_next       = rstep ? advance(rphase_reg, rrev_reg) : rphase_reg;
                coils_driven_next = 1'b1;
            end
            OP_RELEASE: coils_driven_next = 1'b0;
            default: ;
        endcase

        if (op_cmd.load_in)
        begin
            count_next = '0;
        end
    end

    // Result register
    always_comb
    begin
        lcoil_next  = lcoil_reg;
        rcoil_next  = rcoil_reg;
        scount_next = scount_reg;
        if (op_cmd.load_out)
        begin
            lcoil_next  = coils_driven_reg ? phase_pattern(lphase_reg) : '0;
            rcoil_next  = coils_driven_reg ? phase_pattern(rphase_reg) : '0;
            scount_next = count_reg;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg       <= OFFSET_RST;
            spr_reg          <= SPR_RST;
            move_scale_reg   <= MOVE_SCALE_RST;
            turn_scale_reg   <= TURN_SCALE_RST;
            lphase_reg       <= '0;
            rphase_reg       <= '0;
            lrev_reg         <= 1'b0;
            rrev_reg         <= 1'b0;
            in_left_reg      <= 1'b0;
            act_reg          <= ACT_MOVE;
            err_reg          <= '0;
            outer2_reg       <= '0;
            inner2_reg       <= '0;
            coils_driven_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OFFSET:     offset_reg     <= cfg_data[7:0];
                    REG_SPR:        spr_reg        <= cfg_data[7:0];
                    REG_MOVE_SCALE: move_scale_reg <= cfg_data;
                    REG_TURN_SCALE: turn_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            lphase_reg       <= lphase_next;
            rphase_reg       <= rphase_next;
            lrev_reg         <= lrev_next;
            rrev_reg         <= rrev_next;
            in_left_reg      <= in_left_next;
            act_reg          <= act_next;
            err_reg          <= err_next;
            outer2_reg       <= outer2_next;
            inner2_reg       <= inner2_next;
            coils_driven_reg <= coils_driven_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        turn_reg     <= turn_next;
        mag_reg      <= mag_next;
        ang_reg      <= ang_next;
        rout_reg     <= rout_next;
        rin_reg      <= rin_next;
        arc_left_reg <= arc_left_next;
        near_reg     <= near_next;
        prod_reg     <= prod_next;
        qa_reg       <= qa_next;
        ra_reg       <= ra_next;
        aout_reg     <= aout_next;
        ain_reg      <= ain_next;
        lo_reg       <= lo_next;
        nout_reg     <= nout_next;
        count_reg    <= count_next;
        lcoil_reg    <= lcoil_next;
        rcoil_reg    <= rcoil_next;
        scount_reg   <= scount_next;
    end

    assign left_coils  = lcoil_reg;
    assign right_coils = rcoil_reg;
    assign step_count  = scount_reg;

    // A tick always energizes, a release always de-energizes
    `DSM_ASSERT_NEXT(a_tick_drives, clk, rst_n, op_cmd.op == OP_TICK, coils_driven_reg)
    `DSM_ASSERT_NEXT(a_release_frees, clk, rst_n, op_cmd.op == OP_RELEASE, !coils_driven_reg)

endmodule

// ===== hdl/dsm_ctl.sv =====
// Controller: sequences each request through the datapath steps and
// owns both handshakes. Depends on dsm_pkg and the assertion header.
`include "dual_stepper_move_arc_sequencer_unit_assert.svh"

module dsm_ctl import dsm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  status_t dp_status,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output cmd_t    op_cmd
);

    ctl_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       in_fire;

    // Take a request only when idle and the result slot is free or draining
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (dp_status.kind)
                        KIND_SCALED:  state_next = ST_MV_MUL;
                        KIND_ARC:     state_next = ST_ARC_QA;
                        KIND_STEP:    state_next = ST_TICK;
                        KIND_RELEASE: state_next = ST_RELEASE;
                        default:      state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MV_MUL:   state_next = ST_MV_DIV;
            ST_MV_DIV:   state_next = ST_MV_DONE;
            ST_MV_DONE:  state_next = ST_EMIT;
            ST_ARC_QA:   state_next = ST_ARC_AOUT;
            ST_ARC_AOUT: state_next = ST_ARC_AIN;
            ST_ARC_AIN:  state_next = ST_ARC_OLO;
            ST_ARC_OLO:  state_next = ST_ARC_ODIV;
            ST_ARC_ODIV: state_next = ST_ARC_OHI;
            ST_ARC_OHI:  state_next = ST_ARC_ILO;
            ST_ARC_ILO:  state_next = ST_ARC_IDIV;
            ST_ARC_IDIV: state_next = ST_ARC_IHI;
            ST_ARC_IHI:  state_next = ST_ARC_DONE;
            ST_ARC_DONE: state_next = ST_EMIT;
            ST_TICK:     state_next = ST_EMIT;
            ST_RELEASE:  state_next = ST_EMIT;
            ST_EMIT:     state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath command per state
    always_comb
    begin
        op_cmd.load_in  = in_fire;
        op_cmd.load_out = (state_reg == ST_EMIT);
        case (state_reg)
            ST_MV_MUL:   op_cmd.op = OP_MV_MUL;
            ST_MV_DIV:   op_cmd.op = OP_MV_DIV;
            ST_MV_DONE:  op_cmd.op = OP_MV_DONE;
            ST_ARC_QA:   op_cmd.op = OP_ARC_QA;
            ST_ARC_AOUT: op_cmd.op = OP_ARC_AOUT;
            ST_ARC_AIN:  op_cmd.op = OP_ARC_AIN;
            ST_ARC_OLO:  op_cmd.op = OP_ARC_OLO;
            ST_ARC_ODIV: op_cmd.op = OP_ARC_ODIV;
            ST_ARC_OHI:  op_cmd.op = OP_ARC_OHI;
            ST_ARC_ILO:  op_cmd.op = OP_ARC_ILO;
            ST_ARC_IDIV: op_cmd.op = OP_ARC_IDIV;
            ST_ARC_IHI:  op_cmd.op = OP_ARC_IHI;
            ST_ARC_DONE: op_cmd.op = OP_ARC_DONE;
            ST_TICK:     op_cmd.op = OP_TICK;
            ST_RELEASE:  op_cmd.op = OP_RELEASE;
            default:     op_cmd.op = OP_NONE;
        endcase
    end

    // Result valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_EMIT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `DSM_ASSERT_NEXT(a_accept_starts_work, clk, rst_n, in_fire, state_reg != ST_IDLE)
    `DSM_ASSERT_IMP(a_emit_slot_free, clk, rst_n, state_reg == ST_EMIT, !out_valid_reg)
    `DSM_ASSERT_IMP(a_valid_from_emit, clk, rst_n, $rose(out_valid_reg), $past(state_reg == ST_EMIT))

endmodule

// ===== hdl/dual_stepper_move_arc_sequencer_unit.sv =====
// Two-wheel half-step stepper sequencer, top level.
// Channels: cmd (sink) takes mode/amount/radius requests; res (source) returns one
// result per request: both coil patterns and the step count of a move, turn or arc.
// Registers are written through cfg_we/cfg_index/cfg_data, one per clock, no wait.
// Each request runs the controller's steps over the single shared 32x32 multiplier:
//   unused modes: result only; step tick, release: one motor-state update
//   move or turn: scale multiply, reciprocal divide by 1000, update
//   arc: angle split, two radius products, two divides by 360, update
// One request is in work at a time: a new one is taken only while the controller
// is idle, after the last result has been emitted into the result register.
// The next is taken in the cycle the result leaves or in any idle cycle while the
// result register is empty.
// A stalled receiver holds the result in its register and keeps cmd.ready low.
// Reset: configuration returns to offset 30, 40 steps/rev, scales 4244 and 4444;
// phases, directions and Bresenham terms clear and coils count as released until a tick.
// Depends on dsm_pkg, dsm_if, dsm_ctl and dsm_dp.
module dual_stepper_move_arc_sequencer_unit import dsm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dsm_cmd_if.sink               cmd,
    dsm_res_if.source             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    op_cmd;
    status_t dp_status;

    dsm_ctl u_ctl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_status (dp_status),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .op_cmd    (op_cmd)
    );

    dsm_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_cmd      (op_cmd),
        .dp_status   (dp_status),
        .mode        (cmd.mode),
        .amount      (cmd.amount),
        .radius      (cmd.radius),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .left_coils  (res.left_coils),
        .right_coils (res.right_coils),
        .step_count  (res.step_count)
    );

endmodule

// ===== tb/dsm_drive_tracker_pkg.sv =====
// Request and result records for the stepper sequencer testbench, plus a tracker
// that mirrors the sequencer state and holds the results still owed by the block.
// Depends on dsm_pkg.
package dsm_drive_tracker_pkg;
    import dsm_pkg::*;

    typedef struct {
        logic [MODE_W-1:0]       mode;
        logic signed [AMT_W-1:0] amount;
        logic signed [AMT_W-1:0] radius;
    } motion_req_t;

    typedef struct {
        logic [COIL_W-1:0]  left_coils;
        logic [COIL_W-1:0]  right_coils;
        logic [COUNT_W-1:0] step_count;
    } wheel_drive_t;

    class wheel_drive_tracker;
        // register copies
        logic [7:0]  offset_mm;
        logic [7:0]  steps_rev;
        logic [15:0] move_scale;
        logic [15:0] turn_scale;

        // wheel and arc state
        logic [2:0]  left_ph;
        logic [2:0]  right_ph;
        bit          left_rev;
        bit          right_rev;
        bit          inner_left;
        act_cmd_t    active;
        longint      bres_err;
        longint      outer_twice;
        longint      inner_twice;
        bit          energized;

        wheel_drive_t expected_drive[$];
        int           errors;

        function new();
            offset_mm   = OFFSET_RST;
            steps_rev   = SPR_RST;
            move_scale  = MOVE_SCALE_RST;
            turn_scale  = TURN_SCALE_RST;
            left_ph     = '0;
            right_ph    = '0;
            left_rev    = 1'b0;
            right_rev   = 1'b0;
            inner_left  = 1'b0;
            active      = ACT_MOVE;
            bres_err    = 0;
            outer_twice = 0;
            inner_twice = 0;
            energized   = 1'b0;
            errors      = 0;
        endfunction

        // 8-bit registers keep only their low byte
        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_OFFSET:     offset_mm  = value[7:0];
                REG_SPR:        steps_rev  = value[7:0];
                REG_MOVE_SCALE: move_scale = value;
                default:        turn_scale = value;
            endcase
        endfunction

        // half-step sequence, one pattern per phase
        function logic [COIL_W-1:0] coil_pattern(logic [2:0] ph);
            logic [COIL_W-1:0] pat;
            case (ph)
                3'd0:    pat = 4'b1000;
                3'd1:    pat = 4'b1010;
                3'd2:    pat = 4'b0010;
                3'd3:    pat = 4'b0110;
                3'd4:    pat = 4'b0100;
                3'd5:    pat = 4'b0101;
                3'd6:    pat = 4'b0001;
                default: pat = 4'b1001;
            endcase
            return pat;
        endfunction

        function logic [2:0] next_phase(logic [2:0] ph, bit rev);
            return rev ? ph - 3'd1 : ph + 3'd1;
        endfunction

        function void step_inner();
            if (inner_left)
                left_ph = next_phase(left_ph, left_rev);
            else
                right_ph = next_phase(right_ph, right_rev);
        endfunction

        function void step_outer();
            if (inner_left)
                right_ph = next_phase(right_ph, right_rev);
            else
                left_ph = next_phase(left_ph, left_rev);
        endfunction

        // update state for an accepted request and queue the result it owes
        function void take_request(motion_req_t rq);
            longint       amt;
            longint       mag;
            longint       rmag;
            longint       rout;
            longint       rin;
            longint       ang;
            longint       nout;
            longint       nin;
            longint       steps;
            wheel_drive_t owed;
            amt   = rq.amount;
            mag   = (amt < 0) ? -amt : amt;
            steps = 0;
            case (rq.mode)
                MODE_MOVE:
                begin
                    left_rev  = amt < 0;
                    right_rev = amt < 0;
                    active    = ACT_MOVE;
                    steps     = 1 + mag * longint'(move_scale) / 1000;
                end
                MODE_TURN:
                begin
                    // positive or zero angle spins on a reversed right wheel
                    left_rev  = amt < 0;
                    right_rev = !(amt < 0);
                    active    = ACT_TURN;
                    steps     = 1 + mag * longint'(turn_scale) / 1000;
                end
                MODE_ARC:
                begin
                    inner_left = rq.radius >= 0;
                    rmag       = rq.radius;
                    if (rmag < 0)
                        rmag = -rmag;
                    left_rev   = 1'b0;
                    right_rev  = 1'b0;
                    rout       = rmag + longint'(offset_mm);
                    // radius inside the wheel base: inner wheel runs backward
                    if (rmag < longint'(offset_mm))
                    begin
                        rin = longint'(offset_mm) - rmag;
                        if (inner_left)
                            left_rev = 1'b1;
                        else
                            right_rev = 1'b1;
                    end
                    else
                    begin
                        rin = rmag - longint'(offset_mm);
                    end
                    ang         = (amt < 0) ? 0 : amt;
                    nout        = longint'(steps_rev) * rout * ang / 360;
                    nin         = longint'(steps_rev) * rin * ang / 360;
                    outer_twice = 2 * nout;
                    inner_twice = 2 * nin;
                    bres_err    = nout;
                    active      = ACT_ARC;
                    steps       = nout + 1;
                end
                MODE_STEP:
                begin
                    if (active == ACT_ARC)
                    begin
                        step_outer();
                        bres_err = bres_err - inner_twice;
                        if (bres_err <= 0)
                        begin
                            step_inner();
                            bres_err = bres_err + outer_twice;
                        end
                    end
                    else
                    begin
                        left_ph  = next_phase(left_ph, left_rev);
                        right_ph = next_phase(right_ph, right_rev);
                    end
                    energized = 1'b1;
                end
                MODE_RELEASE:
                    energized = 1'b0;
                default: ;
            endcase
            owed.left_coils  = energized ? coil_pattern(left_ph) : '0;
            owed.right_coils = energized ? coil_pattern(right_ph) : '0;
            owed.step_count  = (steps > longint'(COUNT_MAX)) ? COUNT_MAX : steps[COUNT_W-1:0];
            expected_drive.push_back(owed);
        endfunction

        // compare one result with the oldest owed one
        function void check_result(wheel_drive_t got);
            wheel_drive_t owed;
            if (expected_drive.size() == 0)
            begin
                $display("%0t: result with none owed: left %h right %h count %0d",
                         $time, got.left_coils, got.right_coils, got.step_count);
                errors++;
                return;
            end
            owed = expected_drive.pop_front();
            if (got.left_coils !== owed.left_coils)
            begin
                $display("%0t: left_coils expected %h actual %h",
                         $time, owed.left_coils, got.left_coils);
                errors++;
            end
            if (got.right_coils !== owed.right_coils)
            begin
                $display("%0t: right_coils expected %h actual %h",
                         $time, owed.right_coils, got.right_coils);
                errors++;
            end
            if (got.step_count !== owed.step_count)
            begin
                $display("%0t: step_count expected %0d actual %0d",
                         $time, owed.step_count, got.step_count);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== tb/dual_stepper_move_arc_sequencer_unit_tb.sv =====
// Top-level testbench for the two-wheel stepper sequencer: drives move, turn, arc
// and tick requests under several register settings and checks every result.
// Depends on dsm_pkg, dsm_if, the sequencer RTL and dsm_drive_tracker_pkg.
module dual_stepper_move_arc_sequencer_unit_tb;
    import dsm_pkg::*;
    import dsm_drive_tracker_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = MODE_RELEASE + 3'd1;

    typedef enum int {
        SINK_OPEN,
        SINK_THREE_IN_FOUR,
        SINK_COIN,
        SINK_LONG_HOLD
    } sink_style_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    quiet_cycles = 0;

    dsm_cmd_if cmd_ch();
    dsm_res_if res_ch();

    wheel_drive_tracker drive_sb = new();
    motion_req_t        motion_q[$];

    dual_stepper_move_arc_sequencer_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // note accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                drive_sb.take_request('{cmd_ch.mode, cmd_ch.amount, cmd_ch.radius});
            if (res_ch.valid && res_ch.ready)
                drive_sb.check_result('{res_ch.left_coils, res_ch.right_coils,
                                        res_ch.step_count});
        end
    end

    // cycles with no request and no result moving
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("dual_stepper_move_arc_sequencer_unit_tb: FAIL");
        $finish;
    end

    // result receiver; a tick counter redraws its stall style at random
    initial
    begin : result_sink
        sink_style_t style;
        int          tick;
        style = SINK_OPEN;
        tick  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (tick % 256 == 0)
                style = sink_style_t'($urandom_range(0, 3));
            case (style)
                SINK_OPEN:          res_ch.ready <= 1'b1;
                SINK_THREE_IN_FOUR: res_ch.ready <= (tick % 4) != 0;
                SINK_COIN:          res_ch.ready <= 1'($urandom_range(0, 1));
                default:            res_ch.ready <= ((tick / 8) % 2) == 1;
            endcase
        end
    end

    function automatic void add_req(logic [MODE_W-1:0] mode, logic signed [AMT_W-1:0] amount,
                                    logic signed [AMT_W-1:0] radius);
        motion_q.push_back('{mode, amount, radius});
    endfunction

    function automatic logic signed [AMT_W-1:0] any_value();
        return AMT_W'($urandom());
    endfunction

    function automatic logic signed [AMT_W-1:0] linear_amount();
        if ($urandom_range(0, 9) < 6)
            return AMT_W'(int'($urandom_range(0, 1000)) - 500);
        return any_value();
    endfunction

    function automatic logic signed [AMT_W-1:0] arc_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return any_value();
        if (pick == 1)
            return AMT_W'(-int'($urandom_range(1, 360)));
        return AMT_W'($urandom_range(0, 400));
    endfunction

    // radii mostly around the wheel offset so both inner-wheel directions show up
    function automatic logic signed [AMT_W-1:0] arc_radius();
        int pick;
        int mag;
        pick = $urandom_range(0, 9);
        if (pick >= 8)
            return any_value();
        if (pick < 6)
            mag = $urandom_range(0, int'(drive_sb.offset_mm) + 40);
        else
            mag = $urandom_range(0, 2000);
        return $urandom_range(0, 1) ? AMT_W'(-mag) : AMT_W'(mag);
    endfunction

    // extremes, every mode and the named corner cases, at reset settings
    function automatic void build_directed();
        add_req(MODE_STEP, 16'sh7FFF, 16'sh8000);
        add_req(MODE_MOVE, 16'sd0, 16'sd0);
        add_req(MODE_MOVE, 16'sh8000, 16'sh7FFF);
        add_req(MODE_STEP, 16'sd0, 16'sd0);
        add_req(MODE_MOVE, 16'sh7FFF, -16'sd1);
        add_req(MODE_TURN, 16'sd0, 16'sd0);
        add_req(MODE_STEP, -16'sd1, -16'sd1);
        add_req(MODE_TURN, 16'sh8000, 16'sd0);
        add_req(MODE_TURN, 16'sh7FFF, 16'sd0);
        add_req(MODE_RELEASE, -16'sd1, -16'sd1);
        add_req(MODE_SPARE_LO, -16'sd1, -16'sd1);
        add_req(MODE_SPARE_LO + 3'd1, 16'sd0, 16'sd0);
        add_req(MODE_SPARE_LO + 3'd2, 16'sh7FFF, 16'sh8000);
        // inner wheel on the left and running backward
        add_req(MODE_ARC, 16'sd90, 16'sd10);
        repeat (3) add_req(MODE_STEP, 16'sd0, 16'sd0);
        // inner wheel on the right, radius equal to the offset
        add_req(MODE_ARC, 16'sd45, -16'sd30);
        repeat (2) add_req(MODE_STEP, 16'sd0, 16'sd0);
        // saturating count from the widest radius and angle
        add_req(MODE_ARC, 16'sh7FFF, 16'sh8000);
        add_req(MODE_STEP, 16'sd0, 16'sd0);
        // negative angle counts as zero
        add_req(MODE_ARC, -16'sd5, 16'sd0);
        repeat (2) add_req(MODE_STEP, 16'sd0, 16'sd0);
        add_req(MODE_ARC, 16'sd1, 16'sh7FFF);
        add_req(MODE_RELEASE, 16'sd0, 16'sd0);
    endfunction

    // mostly commands followed by runs of ticks, some noise and releases
    function automatic void build_random(int target);
        int pick;
        int ticks;
        while (motion_q.size() < target)
        begin
            pick  = $urandom_range(0, 99);
            ticks = $urandom_range(0, 10);
            if (pick < 45)
            begin
                add_req(MODE_ARC, arc_angle(), arc_radius());
                ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                     : $urandom_range(1, 20);
            end
            else if (pick < 70)
                add_req(MODE_MOVE, linear_amount(), any_value());
            else if (pick < 90)
                add_req(MODE_TURN, linear_amount(), any_value());
            else
            begin
                add_req(MODE_W'($urandom_range(0, 7)), any_value(), any_value());
                ticks = 0;
            end
            repeat (ticks) add_req(MODE_STEP, any_value(), any_value());
            if ($urandom_range(0, 6) == 0)
                add_req(MODE_RELEASE, any_value(), any_value());
        end
    endfunction

    // push the queued requests in bursts with random gaps between them
    task automatic send_queue();
        motion_req_t rq;
        int          burst;
        int          gap;
        burst = $urandom_range(1, 16);
        while (motion_q.size() != 0)
        begin
            rq = motion_q.pop_front();
            cmd_ch.valid  <= 1'b1;
            cmd_ch.mode   <= rq.mode;
            cmd_ch.amount <= rq.amount;
            cmd_ch.radius <= rq.radius;
            @(posedge clk);
            while (!cmd_ch.ready)
                @(posedge clk);
            burst--;
            if (burst == 0)
            begin
                burst = $urandom_range(1, 16);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    cmd_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        cmd_ch.valid <= 1'b0;
    endtask

    // all owed results in, then let the block go quiet
    task automatic settle();
        @(posedge clk);
        while (drive_sb.expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write all four registers on back-to-back clocks; byte registers get junk above
    task automatic apply_config(logic [7:0] offset, logic [7:0] spr, logic [15:0] mv_scale,
                                logic [15:0] tn_scale);
        logic [CFG_DATA_W-1:0] vals[4];
        vals[REG_OFFSET]     = {8'($urandom()), offset};
        vals[REG_SPR]        = {8'($urandom()), spr};
        vals[REG_MOVE_SCALE] = mv_scale;
        vals[REG_TURN_SCALE] = tn_scale;
        for (int i = 0; i < 4; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_reg_t'(i);
            cfg_data  <= vals[i];
            drive_sb.set_reg(cfg_reg_t'(i), vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        rst_n         <= 1'b0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.mode   <= MODE_MOVE;
        cmd_ch.amount <= '0;
        cmd_ch.radius <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_OFFSET;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        build_directed();
        send_queue();
        settle();

        // low extremes
        apply_config(8'd0, 8'd1, 16'd0, 16'd0);
        build_random(300);
        send_queue();
        settle();

        // high extremes
        apply_config(8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
        build_random(300);
        send_queue();
        settle();

        repeat (4)
        begin
            apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                         16'($urandom()), 16'($urandom()));
            build_random(320);
            send_queue();
            settle();
        end

        if (drive_sb.errors == 0 && drive_sb.expected_drive.size() == 0)
            $display("dual_stepper_move_arc_sequencer_unit_tb: PASS");
        else
            $display("dual_stepper_move_arc_sequencer_unit_tb: FAIL");
        $finish;
    end

endmodule
